// ===== rtl/text_console_writer_core_assert.svh =====
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] column;
        logic [BYTE_W-1:0] row;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
        logic              ignored;
    } result_t;

    // Screen row plus ring offset, wrapped once, then scaled to a cell address.
    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [ROW_W-1:0] ring,
        input logic [ROW_W-1:0] scr_row,
        input logic [COL_W-1:0] col
    );
        logic [ROW_W:0]   sum;
        logic [ROW_W-1:0] srow;
        sum = {1'b0, ring} + {1'b0, scr_row};
        if (sum >= (ROW_W+1)'(ROWS))
        begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        srow = sum[ROW_W-1:0];
        return ADDR_W'(srow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    function automatic logic [POS_W-1:0] cursor_pos(
        input logic [ROW_W-1:0] line,
        input logic [COL_W-1:0] col
    );
        return POS_W'(line) * POS_W'(COLUMNS) + POS_W'(col);
    endfunction

endpackage

// ===== rtl/tcw_cell_ram.sv =====
module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tcw_ctrl.sv =====
`include "text_console_writer_core_assert.svh"

module tcw_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tcw_pkg::item_t               in_item,
    input  logic                         out_free,
    output logic                         res_valid,
    output tcw_pkg::result_t             res,
    output logic                         mem_we,
    output logic [tcw_pkg::ADDR_W-1:0]   mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]   mem_wdata,
    output logic [tcw_pkg::ADDR_W-1:0]   mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [tcw_pkg::COL_W-1:0] FULL_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);

    logic [2:0]                   state_reg, state_next;
    logic [tcw_pkg::COL_W-1:0]    col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]    line_reg, line_next;
    logic [tcw_pkg::ROW_W-1:0]    ring_reg, ring_next;
    logic [tcw_pkg::ATTR_W-1:0]   attr_reg;
    logic [tcw_pkg::ADDR_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [tcw_pkg::ADDR_W-1:0]   sweep_last_reg, sweep_last_next;
    logic [tcw_pkg::CELL_W-1:0]   sweep_val_reg, sweep_val_next;
    logic                         sweep_put_reg, sweep_put_next;
    tcw_pkg::item_t               item_reg, item_next;
    logic [tcw_pkg::CELL_W-1:0]   cell_reg, cell_next;
    logic                         scrolled_reg, scrolled_next;
    logic                         ignored_reg, ignored_next;
    logic [tcw_pkg::CELL_W-1:0]   blank;
    logic                         pos_bad;
    logic                         finish;

    assign blank    = {attr_reg, tcw_pkg::BYTE_W'(0)};
    assign in_ready = (state_reg == S_IDLE);
    assign pos_bad  = (item_reg.column >= tcw_pkg::BYTE_W'(tcw_pkg::COLUMNS))
                   || (item_reg.row >= tcw_pkg::BYTE_W'(tcw_pkg::ROWS));
    assign mem_raddr = tcw_pkg::store_addr(ring_reg, item_reg.row[tcw_pkg::ROW_W-1:0],
                                           item_reg.column[tcw_pkg::COL_W-1:0]);

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        line_next       = line_reg;
        ring_next       = ring_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_val_next  = sweep_val_reg;
        sweep_put_next  = sweep_put_reg;
        item_next       = item_reg;
        cell_next       = cell_reg;
        scrolled_next   = scrolled_reg;
        ignored_next    = ignored_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = sweep_val_reg;
        res_valid       = 1'b0;
        finish          = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::BYTE_W'(0)};
                if (sweep_addr_reg == LAST_CELL)
                begin
                    sweep_addr_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cell_next     = '0;
                scrolled_next = 1'b0;
                ignored_next  = 1'b0;
                case (item_reg.action)
                    tcw_pkg::ACT_PUT:
                    begin
                        if (item_reg.char_code == tcw_pkg::CH_BS)
                        begin
                            if ((col_reg == '0) && (line_reg == '0))
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                if (col_reg == '0)
                                begin
                                    line_next = line_reg - 1'b1;
                                    col_next  = LAST_COL;
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                                mem_we    = 1'b1;
                                mem_waddr = tcw_pkg::store_addr(ring_reg, line_next, col_next);
                                mem_wdata = blank;
                                cell_next = blank;
                                finish    = 1'b1;
                            end
                        end
                        else if ((item_reg.char_code == tcw_pkg::CH_LF) || (col_reg >= FULL_COL))
                        begin
                            col_next = '0;
                            if (line_reg < LAST_ROW)
                            begin
                                line_next = line_reg + 1'b1;
                                if (item_reg.char_code == tcw_pkg::CH_LF)
                                begin
                                    finish = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_PUT;
                                end
                            end
                            else
                            begin
                                sweep_addr_next = tcw_pkg::store_addr(ring_reg, '0, '0);
                                sweep_last_next = sweep_addr_next
                                                + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
                                sweep_val_next  = '0;
                                sweep_put_next  = (item_reg.char_code != tcw_pkg::CH_LF);
                                ring_next       = (ring_reg == LAST_ROW) ? '0 : ring_reg + 1'b1;
                                scrolled_next   = 1'b1;
                                state_next      = S_SWEEP;
                            end
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = tcw_pkg::store_addr(ring_reg, line_reg, col_reg);
                            mem_wdata = {attr_reg, item_reg.char_code};
                            cell_next = {attr_reg, item_reg.char_code};
                            col_next  = col_reg + 1'b1;
                            finish    = 1'b1;
                        end
                    end
                    tcw_pkg::ACT_SET:
                    begin
                        if (pos_bad)
                        begin
                            ignored_next = 1'b1;
                        end
                        else
                        begin
                            col_next  = item_reg.column[tcw_pkg::COL_W-1:0];
                            line_next = item_reg.row[tcw_pkg::ROW_W-1:0];
                        end
                        finish = 1'b1;
                    end
                    tcw_pkg::ACT_READ:
                    begin
                        if (pos_bad)
                        begin
                            ignored_next = 1'b1;
                            finish       = 1'b1;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        sweep_addr_next = '0;
                        sweep_last_next = LAST_CELL;
                        sweep_val_next  = blank;
                        sweep_put_next  = 1'b0;
                        state_next      = S_SWEEP;
                    end
                endcase
            end
            S_SWEEP:
            begin
                mem_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    if (sweep_put_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            S_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = tcw_pkg::store_addr(ring_reg, line_reg, col_reg);
                mem_wdata = {attr_reg, item_reg.char_code};
                cell_next = {attr_reg, item_reg.char_code};
                col_next  = col_reg + 1'b1;
                finish    = 1'b1;
            end
            S_READ:
            begin
                cell_next = mem_rdata;
                finish    = 1'b1;
            end
            S_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_comb
    begin
        res.cursor_column   = col_next;
        res.cursor_row      = line_next;
        res.cursor_position = tcw_pkg::cursor_pos(line_next, col_next);
        res.cell_value      = cell_next;
        res.scrolled        = scrolled_next;
        res.ignored         = ignored_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            col_reg        <= '0;
            line_reg       <= '0;
            ring_reg       <= '0;
            attr_reg       <= tcw_pkg::ATTR_RESET;
            sweep_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            line_reg       <= line_next;
            ring_reg       <= ring_next;
            sweep_addr_reg <= sweep_addr_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_last_reg <= sweep_last_next;
        sweep_val_reg  <= sweep_val_next;
        sweep_put_reg  <= sweep_put_next;
        item_reg       <= item_next;
        cell_reg       <= cell_next;
        scrolled_reg   <= scrolled_next;
        ignored_reg    <= ignored_next;
    end

    `TCW_ASSERT_NOW(a_line_range, clk, rst_n, 1'b1, line_reg <= LAST_ROW, "cursor row out of range")
    `TCW_ASSERT_NOW(a_col_range, clk, rst_n, 1'b1, col_reg <= FULL_COL, "cursor column out of range")
    `TCW_ASSERT_NOW(a_ring_range, clk, rst_n, 1'b1, ring_reg <= LAST_ROW, "ring offset out of range")
    `TCW_ASSERT_NOW(a_res_room, clk, rst_n, res_valid, out_free, "result issued with output full")
    `TCW_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_reg == S_EXEC, "accepted item not executed")

endmodule

// ===== rtl/text_console_writer_core.sv =====
// Flow: a plain character, line feed, backspace or set_cursor completes in the execute state;
// read_cell and a wrapping character then pass the read or put state; a scroll first sweeps
// the 80 cells of the oldest row, clear_screen sweeps all 2000, and a full output holds a result.
// Input: one item at a time, taken once the previous result is in the output register;
// scroll and clear walk one cell a cycle.
// Reset: rst_n clears cursor and ring offset, then an init pass fills every cell with 0x0700.
module text_console_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code, column, row
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // cursor_column, cursor_row, cursor_position,
                                        // cell_value, scrolled, ignored
);

    tcw_pkg::item_t                 in_item;
    tcw_pkg::result_t               res;
    logic                           res_valid;
    logic                           out_free;
    logic                           mem_we;
    logic [tcw_pkg::ADDR_W-1:0]     mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
    logic [tcw_pkg::ADDR_W-1:0]     mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]     mem_rdata;
    logic                           m_valid_reg;
    logic [47:0]                    m_data_reg;

    assign in_item.action    = s_axis_tuser;
    assign in_item.char_code = s_axis_tdata[7:0];
    assign in_item.column    = s_axis_tdata[15:8];
    assign in_item.row       = s_axis_tdata[23:16];

    assign out_free = !m_valid_reg || m_axis_tready;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tcw_cell_ram #(
        .DEPTH  (tcw_pkg::CELLS),
        .ADDR_W (tcw_pkg::ADDR_W),
        .DATA_W (tcw_pkg::CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_data_reg <= {7'b0, res.ignored, res.scrolled, res.cell_value,
                           res.cursor_position, res.cursor_row, res.cursor_column};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== sim/tb_text_console_writer_core.sv =====
module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int CLEAR_CAP      = 40;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 259;
    localparam int HOLD_CYCLES    = 400;
    localparam int PLAN_ROWS      = 25;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t want;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_line;
    logic [ROW_W-1:0]  ring_pos;
    logic [ATTR_W-1:0] attr_now;

    result_t pending_results [$];
    step_t   plan [PLAN_ROWS];
    logic [ATTR_W-1:0] phase_attr [PHASES];

    int  mismatch_count = 0;
    int  clears_issued  = 0;
    int  cycle_count    = 0;
    bit  quiet          = 1'b0;
    bit  hold_req       = 1'b0;

    text_console_writer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int cell_slot(int scr_row, int col);
        int srow;
        srow = (int'(ring_pos) + scr_row) % ROWS;
        if (col >= COLUMNS)
        begin
            col = COLUMNS - 1;
        end
        return srow * COLUMNS + col;
    endfunction

    // Moves to the start of the next row; on the last row the oldest store row
    // is zeroed and becomes the new bottom row.
    function automatic logic advance_line();
        cur_col = '0;
        if (int'(cur_line) < ROWS - 1)
        begin
            cur_line = cur_line + 1'b1;
            return 1'b0;
        end
        for (int i = 0; i < COLUMNS; i++)
        begin
            screen_mem[int'(ring_pos) * COLUMNS + i] = '0;
        end
        ring_pos = ROW_W'((int'(ring_pos) + 1) % ROWS);
        return 1'b1;
    endfunction

    function automatic result_t console_step(item_t it);
        result_t           res;
        logic [CELL_W-1:0] blank;
        res   = '0;
        blank = {attr_now, 8'h00};
        case (it.action)
            ACT_PUT:
            begin
                if (it.char_code == CH_LF)
                begin
                    res.scrolled = advance_line();
                end
                else if (it.char_code == CH_BS)
                begin
                    if (cur_col == '0 && cur_line != '0)
                    begin
                        cur_line = cur_line - 1'b1;
                        cur_col  = COL_W'(COLUMNS);
                    end
                    if (cur_col != '0)
                    begin
                        cur_col = cur_col - 1'b1;
                        screen_mem[cell_slot(int'(cur_line), int'(cur_col))] = blank;
                        res.cell_value = blank;
                    end
                end
                else
                begin
                    if (int'(cur_col) >= COLUMNS)
                    begin
                        res.scrolled = advance_line();
                    end
                    res.cell_value = blank | CELL_W'(it.char_code);
                    screen_mem[cell_slot(int'(cur_line), int'(cur_col))] = res.cell_value;
                    cur_col = cur_col + 1'b1;
                end
            end
            ACT_SET:
            begin
                if (int'(it.column) >= COLUMNS || int'(it.row) >= ROWS)
                begin
                    res.ignored = 1'b1;
                end
                else
                begin
                    cur_col  = COL_W'(it.column);
                    cur_line = ROW_W'(it.row);
                end
            end
            ACT_READ:
            begin
                if (int'(it.column) >= COLUMNS || int'(it.row) >= ROWS)
                begin
                    res.ignored = 1'b1;
                end
                else
                begin
                    res.cell_value = screen_mem[cell_slot(int'(it.row), int'(it.column))];
                end
            end
            default:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    screen_mem[i] = blank;
                end
            end
        endcase
        res.cursor_column   = cur_col;
        res.cursor_row      = cur_line;
        res.cursor_position = POS_W'(int'(cur_line) * COLUMNS + int'(cur_col));
        return res;
    endfunction

    // Mostly character writes of random bytes with line feeds and backspaces; cursor moves and
    // reads favor the bottom rows and the line ends so that wraps and scrolls
    // happen often.
    function automatic item_t random_item();
        item_t it;
        int    pick;
        it.action    = ACT_PUT;
        it.char_code = 8'($urandom_range(0, 255));
        it.column    = 8'($urandom_range(0, 255));
        it.row       = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 199);
        if (pick >= 197 && clears_issued < CLEAR_CAP)
        begin
            it.action = ACT_CLEAR;
            clears_issued++;
        end
        else if (pick >= 145)
        begin
            it.action = ACT_READ;
        end
        else if (pick >= 120)
        begin
            it.action = ACT_SET;
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                it.char_code = CH_LF;
            end
            else if (pick == 2)
            begin
                it.char_code = CH_BS;
            end
        end
        if ((it.action == ACT_SET || it.action == ACT_READ) && $urandom_range(0, 5) != 0)
        begin
            it.column = 8'($urandom_range(0, 1) ? $urandom_range(70, 79) : $urandom_range(0, 79));
            it.row    = 8'($urandom_range(0, 1) ? $urandom_range(20, 24) : $urandom_range(0, 24));
        end
        return it;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(logic [47:0] data);
        result_t got;
        result_t want;
        {got.ignored, got.scrolled, got.cell_value, got.cursor_position,
         got.cursor_row, got.cursor_column} = data[40:0];
        if (pending_results.size() == 0)
        begin
            flag_mismatch("transaction with no result pending", data, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.cursor_column != want.cursor_column)
            flag_mismatch("cursor_column", got.cursor_column, want.cursor_column);
        if (got.cursor_row != want.cursor_row)
            flag_mismatch("cursor_row", got.cursor_row, want.cursor_row);
        if (got.cursor_position != want.cursor_position)
            flag_mismatch("cursor_position", got.cursor_position, want.cursor_position);
        if (got.cell_value != want.cell_value)
            flag_mismatch("cell_value", got.cell_value, want.cell_value);
        if (got.scrolled != want.scrolled)
            flag_mismatch("scrolled", got.scrolled, want.scrolled);
        if (got.ignored != want.ignored)
            flag_mismatch("ignored", got.ignored, want.ignored);
    endtask

    task automatic send_item(item_t it, logic typed, result_t want);
        result_t predicted;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.row, it.column, it.char_code};
        s_axis_tuser  <= it.action;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = console_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(m_axis_tdata);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_PUT;

        for (int i = 0; i < CELLS; i++)
        begin
            screen_mem[i] = {ATTR_RESET, 8'h00};
        end
        cur_col  = '0;
        cur_line = '0;
        ring_pos = '0;
        attr_now = ATTR_RESET;

        // Columns: action, char_code, column, row | typed | cursor_column,
        // cursor_row, cursor_position, cell_value, scrolled, ignored.
        plan = '{
            '{'{ACT_READ,  8'h00, 8'd0,   8'd0},   1'b1, '{7'd0,  5'd0,  11'd0,    16'h0700, 1'b0, 1'b0}},
            '{'{ACT_READ,  8'h00, 8'd79,  8'd24},  1'b1, '{7'd0,  5'd0,  11'd0,    16'h0700, 1'b0, 1'b0}},
            '{'{ACT_READ,  8'h00, 8'd80,  8'd0},   1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0, 1'b1}},
            '{'{ACT_READ,  8'h00, 8'd0,   8'd25},  1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0, 1'b1}},
            '{'{ACT_READ,  8'hFF, 8'd255, 8'd255}, 1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0, 1'b1}},
            '{'{ACT_SET,   8'h00, 8'd80,  8'd0},   1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0, 1'b1}},
            '{'{ACT_SET,   8'h00, 8'd0,   8'd255}, 1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0, 1'b1}},
            '{'{ACT_PUT,   CH_BS, 8'd0,   8'd0},   1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0, 1'b0}},
            '{'{ACT_PUT,   8'h48, 8'd0,   8'd0},   1'b1, '{7'd1,  5'd0,  11'd1,    16'h0748, 1'b0, 1'b0}},
            '{'{ACT_PUT,   8'h00, 8'd255, 8'd255}, 1'b0, '0},
            '{'{ACT_PUT,   8'hFF, 8'd0,   8'd0},   1'b0, '0},
            '{'{ACT_PUT,   CH_LF, 8'd0,   8'd0},   1'b1, '{7'd0,  5'd1,  11'd80,   16'h0000, 1'b0, 1'b0}},
            '{'{ACT_PUT,   CH_BS, 8'd0,   8'd0},   1'b1, '{7'd79, 5'd0,  11'd79,   16'h0700, 1'b0, 1'b0}},
            '{'{ACT_SET,   8'h00, 8'd79,  8'd24},  1'b1, '{7'd79, 5'd24, 11'd1999, 16'h0000, 1'b0, 1'b0}},
            '{'{ACT_PUT,   8'h41, 8'd0,   8'd0},   1'b1, '{7'd80, 5'd24, 11'd2000, 16'h0741, 1'b0, 1'b0}},
            '{'{ACT_PUT,   8'h42, 8'd0,   8'd0},   1'b1, '{7'd1,  5'd24, 11'd1921, 16'h0742, 1'b1, 1'b0}},
            '{'{ACT_PUT,   CH_LF, 8'd0,   8'd0},   1'b1, '{7'd0,  5'd24, 11'd1920, 16'h0000, 1'b1, 1'b0}},
            '{'{ACT_READ,  8'h00, 8'd0,   8'd23},  1'b0, '0},
            '{'{ACT_READ,  8'h00, 8'd79,  8'd24},  1'b0, '0},
            '{'{ACT_SET,   8'h00, 8'd0,   8'd0},   1'b0, '0},
            '{'{ACT_PUT,   CH_BS, 8'd0,   8'd0},   1'b0, '0},
            '{'{ACT_CLEAR, 8'h00, 8'd0,   8'd0},   1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0, 1'b0}},
            '{'{ACT_READ,  8'h00, 8'd40,  8'd12},  1'b0, '0},
            '{'{ACT_SET,   8'h00, 8'd0,   8'd24},  1'b0, '0},
            '{'{ACT_PUT,   CH_BS, 8'd0,   8'd0},   1'b0, '0}
        };
        phase_attr = '{8'h00, 8'hFF, 8'($urandom), 8'h4F, 8'($urandom), ATTR_RESET};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            send_item(plan[i].it, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            quiesce();
            cfg_data <= phase_attr[p];
            cfg_we   <= 1'b1;
            @(posedge clk);
            cfg_we   <= 1'b0;
            attr_now = phase_attr[p];
            quiet    = (p == PHASES - 1);
            if (p == 1)
            begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_item(), 1'b0, '0);
            end
        end

        quiesce();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
